### src/mrrl_pkg.sv
`timescale 1ns / 1ps
// Package for the motion report rate limiter: field widths, item kind codes,
// register indexes and configuration reset values. No dependencies.
package mrrl_pkg;

   // Field widths
   localparam int TIME_W  = 63;
   localparam int TYPE_W  = 8;
   localparam int CODE_W  = 16;
   localparam int VALUE_W = 32;
   localparam int ACC_W   = 16;
   localparam int IVL_W   = 20;
   localparam int KIND_W  = 2;
   localparam int CNT_W   = 2;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 20;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_MOTION    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FETCH     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TRANSPORT = 2'd2;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_MATCH_TYPE    = 3'd0;
   localparam logic [IDX_W-1:0] REG_CODE_X        = 3'd1;
   localparam logic [IDX_W-1:0] REG_CODE_Y        = 3'd2;
   localparam logic [IDX_W-1:0] REG_CODES_IN_USE  = 3'd3;
   localparam logic [IDX_W-1:0] REG_WIRED_IVL     = 3'd4;
   localparam logic [IDX_W-1:0] REG_WIRELESS_IVL  = 3'd5;

   // Register reset values
   localparam logic [TYPE_W-1:0] RST_MATCH_TYPE   = 8'd2;
   localparam logic [CODE_W-1:0] RST_CODE_X       = 16'd0;
   localparam logic [CODE_W-1:0] RST_CODE_Y       = 16'd1;
   localparam logic [CNT_W-1:0]  RST_CODES_IN_USE = 2'd2;
   localparam logic [IVL_W-1:0]  RST_WIRED_IVL    = 20'd1000;
   localparam logic [IVL_W-1:0]  RST_WIRELESS_IVL = 20'd7000;

   // Flush delay ceiling
   localparam logic [IVL_W-1:0] DELAY_MAX = 20'hFFFFF;

   // Number of motion axes
   localparam int NUM_AXES_DEF = 2;

   // Transport modes
   localparam logic MODE_WIRED = 1'b0;

endpackage

### src/motion_report_rate_limiter_top.sv
`timescale 1ns / 1ps
// Motion report rate limiter: single-pass datapath between an input register
// and a result register. Depends on mrrl_pkg.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | kind, now_us, event fields
//   rsp_    | out       | rsp_valid / rsp_stall | forward, value, kick, report
//   csr_    | in        | csr_write             | csr_index, csr_wdata
//
// Each transaction goes from acceptance into the input register, then
// through the compare/add logic into the result register.
// A new transaction is taken every cycle while results drain.
// req_stall rises only when both registers are full and rsp_stall is high.
// Reset (synchronous) loads the register defaults and clears the motion state.
module motion_report_rate_limiter_top #(
   parameter int NUM_AXES = mrrl_pkg::NUM_AXES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mrrl_pkg::KIND_W-1:0]         req_kind,
   input  logic [mrrl_pkg::TIME_W-1:0]         req_now_us,
   input  logic [mrrl_pkg::TYPE_W-1:0]         req_event_type,
   input  logic [mrrl_pkg::CODE_W-1:0]         req_event_code,
   input  logic signed [mrrl_pkg::VALUE_W-1:0] req_event_value,
   input  logic                                req_event_sync,
   input  logic                                req_new_transport,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_forward,
   output logic signed [mrrl_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                                rsp_out_sync,
   output logic                                rsp_kick_send,
   output logic                                rsp_schedule_flush,
   output logic [mrrl_pkg::IVL_W-1:0]          rsp_flush_delay_us,
   output logic signed [mrrl_pkg::ACC_W-1:0]   rsp_report_dx,
   output logic signed [mrrl_pkg::ACC_W-1:0]   rsp_report_dy,
   output logic                                rsp_moved,
   // configuration port
   input  logic                                csr_write,
   input  logic [mrrl_pkg::IDX_W-1:0]          csr_index,
   input  logic [mrrl_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int TW = mrrl_pkg::TIME_W;
   localparam int AW = mrrl_pkg::ACC_W;
   localparam int IW = mrrl_pkg::IVL_W;

   // saturate a 33-bit sum to 16 bits
   function automatic logic signed [AW-1:0] sat16(input logic signed [32:0] v);
      logic signed [AW-1:0] r;
      if (v < -33'sd32768)
         r = -16'sd32768;
      else if (v > 33'sd32767)
         r = 16'sd32767;
      else
         r = v[AW-1:0];
      return r;
   endfunction

   // configuration registers
   logic [mrrl_pkg::TYPE_W-1:0] match_type_ff;
   logic [mrrl_pkg::CODE_W-1:0] code_x_ff, code_y_ff;
   logic [mrrl_pkg::CNT_W-1:0]  codes_in_use_ff;
   logic [IW-1:0]               wired_ivl_ff, wireless_ivl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_type_ff   <= mrrl_pkg::RST_MATCH_TYPE;
         code_x_ff       <= mrrl_pkg::RST_CODE_X;
         code_y_ff       <= mrrl_pkg::RST_CODE_Y;
         codes_in_use_ff <= mrrl_pkg::RST_CODES_IN_USE;
         wired_ivl_ff    <= mrrl_pkg::RST_WIRED_IVL;
         wireless_ivl_ff <= mrrl_pkg::RST_WIRELESS_IVL;
      end else if (csr_write) begin
         unique case (csr_index)
            mrrl_pkg::REG_MATCH_TYPE:   match_type_ff   <= csr_wdata[mrrl_pkg::TYPE_W-1:0];
            mrrl_pkg::REG_CODE_X:       code_x_ff       <= csr_wdata[mrrl_pkg::CODE_W-1:0];
            mrrl_pkg::REG_CODE_Y:       code_y_ff       <= csr_wdata[mrrl_pkg::CODE_W-1:0];
            mrrl_pkg::REG_CODES_IN_USE: codes_in_use_ff <= csr_wdata[mrrl_pkg::CNT_W-1:0];
            mrrl_pkg::REG_WIRED_IVL:    wired_ivl_ff    <= csr_wdata[IW-1:0];
            mrrl_pkg::REG_WIRELESS_IVL: wireless_ivl_ff <= csr_wdata[IW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic                                in_valid_ff;
   logic [mrrl_pkg::KIND_W-1:0]         in_kind_ff;
   logic [TW-1:0]                       in_now_ff;
   logic [mrrl_pkg::TYPE_W-1:0]         in_type_ff;
   logic [mrrl_pkg::CODE_W-1:0]         in_code_ff;
   logic signed [mrrl_pkg::VALUE_W-1:0] in_value_ff;
   logic                                in_sync_ff;
   logic                                in_newt_ff;

   logic advance;
   logic req_take;

   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_take)
         in_valid_ff <= 1'b1;
      else if (advance)
         in_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff  <= req_kind;
         in_now_ff   <= req_now_us;
         in_type_ff  <= req_event_type;
         in_code_ff  <= req_event_code;
         in_value_ff <= req_event_value;
         in_sync_ff  <= req_event_sync;
         in_newt_ff  <= req_new_transport;
      end
   end

   // motion state
   logic signed [AW-1:0] accum_ff [NUM_AXES];
   logic signed [AW-1:0] accum_in [NUM_AXES];
   logic [NUM_AXES-1:0]  sync_seen_ff, sync_seen_in;
   logic [TW-1:0]        last_ff, last_in;
   logic                 open_ff, open_in;
   logic                 may_ff, may_in;
   logic                 mode_ff, mode_in;

   // result register
   logic                                rsp_valid_ff;
   logic                                fwd_ff, fwd_in;
   logic signed [mrrl_pkg::VALUE_W-1:0] oval_ff, oval_in;
   logic                                osync_ff, osync_in;
   logic                                kick_ff, kick_in;
   logic                                flush_ff, flush_in;
   logic [IW-1:0]                       delay_ff, delay_in;
   logic signed [AW-1:0]                dx_ff, dx_in, dy_ff, dy_in;
   logic                                motion_ff, motion_in;

   // time arithmetic, all side by side on the registered time
   logic [TW:0]   diff_full;
   logic [TW-1:0] diff, rev, last_plus;
   logic          back, ge_wired, gt_2wired, ge_guard;
   logic [IW:0]   back_sum;
   logic [IW-1:0] fwd_delay, back_delay;

   assign diff_full = {1'b0, in_now_ff} - {1'b0, last_ff};
   assign back      = diff_full[TW];
   assign diff      = diff_full[TW-1:0];
   assign rev       = last_ff - in_now_ff;
   assign last_plus = last_ff + {{(TW-IW){1'b0}}, wired_ivl_ff};
   assign ge_wired  = diff >= {{(TW-IW){1'b0}}, wired_ivl_ff};
   assign gt_2wired = diff > {{(TW-IW-1){1'b0}}, wired_ivl_ff, 1'b0};
   assign ge_guard  = diff >= {{(TW-IW){1'b0}}, wireless_ivl_ff};
   assign fwd_delay = wireless_ivl_ff - diff[IW-1:0];
   assign back_sum  = {1'b0, wireless_ivl_ff} + {1'b0, rev[IW-1:0]};
   assign back_delay = (rev > {{(TW-IW){1'b0}}, mrrl_pkg::DELAY_MAX} || back_sum[IW])
                       ? mrrl_pkg::DELAY_MAX : back_sum[IW-1:0];

   // axis lookup: first axis code wins
   logic [mrrl_pkg::CNT_W-1:0] codes_eff;
   logic [NUM_AXES-1:0]        axis_sel;
   logic                       matched;
   logic signed [AW-1:0]       cur_acc;
   logic                       cur_sync;
   logic signed [AW-1:0]       acc_sum;

   assign codes_eff = (codes_in_use_ff > mrrl_pkg::CNT_W'(NUM_AXES))
                      ? mrrl_pkg::CNT_W'(NUM_AXES) : codes_in_use_ff;

   always_comb begin
      logic                        taken;
      logic [mrrl_pkg::CODE_W-1:0] acode;
      taken    = 1'b0;
      axis_sel = '0;
      cur_acc  = '0;
      cur_sync = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         acode = (a == 0) ? code_x_ff : code_y_ff;
         if (!taken && codes_eff > mrrl_pkg::CNT_W'(a) && in_code_ff == acode) begin
            axis_sel[a] = 1'b1;
            taken       = 1'b1;
         end
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         if (axis_sel[a]) begin
            cur_acc  = accum_ff[a];
            cur_sync = sync_seen_ff[a];
         end
      end
   end

   assign matched = (in_type_ff == match_type_ff) && (|axis_sel);
   assign acc_sum = sat16($signed({cur_acc[AW-1], {(32-AW){cur_acc[AW-1]}}, cur_acc})
                          + $signed({in_value_ff[31], in_value_ff}));

   // per-transaction next state and result
   always_comb begin
      logic open_v, may_v, s;
      accum_in     = accum_ff;
      sync_seen_in = sync_seen_ff;
      last_in      = last_ff;
      open_in      = open_ff;
      may_in       = may_ff;
      mode_in      = mode_ff;
      fwd_in       = 1'b0;
      oval_in      = '0;
      osync_in     = 1'b0;
      kick_in      = 1'b0;
      flush_in     = 1'b0;
      delay_in     = '0;
      dx_in        = '0;
      dy_in        = '0;
      motion_in    = 1'b0;
      open_v       = open_ff;
      may_v        = may_ff;
      s            = 1'b0;

      unique case (in_kind_ff)
         mrrl_pkg::KIND_FETCH: begin
            dx_in     = accum_ff[0];
            dy_in     = (NUM_AXES >= 2) ? accum_ff[NUM_AXES-1] : '0;
            motion_in = (dx_in != '0) || (dy_in != '0);
            for (int a = 0; a < NUM_AXES; a++)
               accum_in[a] = '0;
            sync_seen_in = '0;
            if (motion_in)
               last_in = in_now_ff;
         end
         mrrl_pkg::KIND_TRANSPORT: begin
            if (in_newt_ff != mode_ff) begin
               mode_in = in_newt_ff;
               for (int a = 0; a < NUM_AXES; a++)
                  accum_in[a] = '0;
               sync_seen_in = '0;
               last_in      = in_now_ff;
               open_in      = 1'b0;
               may_in       = 1'b0;
            end
         end
         mrrl_pkg::KIND_MOTION: begin
            if (!matched) begin
               // not ours: pass through unchanged
               fwd_in   = 1'b1;
               oval_in  = in_value_ff;
               osync_in = in_sync_ff;
            end else if (mode_ff != mrrl_pkg::MODE_WIRED) begin
               // wireless: accumulate, decide kick or flush at frame end
               for (int a = 0; a < NUM_AXES; a++) begin
                  if (axis_sel[a]) begin
                     accum_in[a]     = acc_sum;
                     sync_seen_in[a] = cur_sync || in_sync_ff;
                  end
               end
               if (in_sync_ff) begin
                  if (last_ff == '0 || (!back && ge_guard)) begin
                     kick_in = 1'b1;
                  end else begin
                     flush_in = 1'b1;
                     delay_in = back ? back_delay : fwd_delay;
                  end
               end
            end else begin
               // wired: first event of a frame decides
               if (!open_ff || back) begin
                  open_v = 1'b1;
                  may_v  = back || ge_wired;
               end
               if (!may_v) begin
                  for (int a = 0; a < NUM_AXES; a++) begin
                     if (axis_sel[a]) begin
                        accum_in[a]     = acc_sum;
                        sync_seen_in[a] = cur_sync || in_sync_ff;
                     end
                  end
                  if (in_sync_ff)
                     open_v = 1'b0;
               end else begin
                  s = in_sync_ff || cur_sync;
                  for (int a = 0; a < NUM_AXES; a++) begin
                     if (axis_sel[a]) begin
                        accum_in[a]     = '0;
                        sync_seen_in[a] = 1'b0;
                     end
                  end
                  if (s) begin
                     last_in = (back || gt_2wired) ? in_now_ff : last_plus;
                     open_v  = 1'b0;
                  end
                  fwd_in   = 1'b1;
                  oval_in  = {{(32-AW){acc_sum[AW-1]}}, acc_sum};
                  osync_in = s;
               end
               open_in = open_v;
               may_in  = may_v;
            end
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++)
            accum_ff[a] <= '0;
         sync_seen_ff <= '0;
         last_ff      <= '0;
         open_ff      <= 1'b0;
         may_ff       <= 1'b0;
         mode_ff      <= mrrl_pkg::MODE_WIRED;
      end else if (advance) begin
         accum_ff     <= accum_in;
         sync_seen_ff <= sync_seen_in;
         last_ff      <= last_in;
         open_ff      <= open_in;
         may_ff       <= may_in;
         mode_ff      <= mode_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_ff    <= fwd_in;
         oval_ff   <= oval_in;
         osync_ff  <= osync_in;
         kick_ff   <= kick_in;
         flush_ff  <= flush_in;
         delay_ff  <= delay_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         motion_ff <= motion_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_forward        = fwd_ff;
   assign rsp_out_value      = oval_ff;
   assign rsp_out_sync       = osync_ff;
   assign rsp_kick_send      = kick_ff;
   assign rsp_schedule_flush = flush_ff;
   assign rsp_flush_delay_us = delay_ff;
   assign rsp_report_dx      = dx_ff;
   assign rsp_report_dy      = dy_ff;
   assign rsp_moved          = motion_ff;

endmodule
